// ----- src/glr_pkg.sv -----
// Package: shared constants, codes and defaults of the glyph range locator.
package glr_pkg;

	// Default sizes handed to the top level.
	localparam int RANGES_DEFAULT    = 32;
	localparam int ENTRIES_DEFAULT   = 4096;
	localparam int BOX_WIDTH_DEFAULT = 16;

	// Input item operation codes.
	typedef enum logic [1:0] {
		MODE_LOAD_RANGE = 2'd0,
		MODE_LOAD_GLYPH = 2'd1,
		MODE_LOOKUP     = 2'd2,
		MODE_NONE       = 2'd3
	} mode_t;

	// Configuration register indexes (byte address / 4).
	localparam logic [1:0] REG_FONT_HEIGHT = 2'd0;
	localparam logic [1:0] REG_RANGE_COUNT = 2'd1;
	localparam logic [1:0] REG_PIXEL_BASE  = 2'd2;

	// Register reset values.
	localparam logic [7:0]  FONT_HEIGHT_RESET = 8'd16;
	localparam logic [5:0]  RANGE_COUNT_RESET = 6'd0;
	localparam logic [31:0] PIXEL_BASE_RESET  = 32'd0;

	// Glyph word layout: width byte above a 24-bit bitmap offset.
	localparam int WIDTH_SHIFT = 24;
	localparam logic [31:0] OFFSET_MASK = 32'h00FF_FFFF;

endpackage

// ----- src/glr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module glr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/glyph_range_locator_unit.sv -----
// Top level: glyph range locator with range scan, glyph fetch and fallback box rows.
//
// Usage. An item is transferred when start is high and busy is low. Mode 0 writes
// one character range slot (first code, length, base glyph index) and mode 1 writes
// one glyph word; both finish at the transfer edge, produce no result and leave busy
// low, so loads can stream one per cycle. Mode 3 is ignored. Mode 2 looks up
// char_code: the range memory is read one slot per cycle, in slot order, over the
// first min(range_count, RANGES) slots, and the first slot holding the code wins.
// On a hit the glyph memory is read once and a single result follows. A miss, once
// the scan is through, passes the box setup state and then shows the box rows, one
// row per cycle, up to BOX_WIDTH rows (one result if font_height is zero). The speed
// is set by the single read port of the range memory, one slot per cycle.
// Each result sits on the result ports for exactly one cycle with strobe high; the
// receiver cannot stall, so there is no back pressure. busy stays high from the
// lookup transfer until the cycle that shows its last result.
// Reset clears the control state and loads the registers with font_height 16,
// range_count 0 and pixel_base 0. The table memories are not cleared; a lookup must
// only touch slots and glyph words that have been written.
// Configuration goes through the APB-style port; the user must write it only while
// the block is idle, which the block itself does not enforce. pready is always high
// and reads return the register values. ENTRIES must be a power of two: the glyph
// index is reduced by keeping its low bits.
module glyph_range_locator_unit #(
	parameter int RANGES    = glr_pkg::RANGES_DEFAULT,
	parameter int ENTRIES   = glr_pkg::ENTRIES_DEFAULT,
	parameter int BOX_WIDTH = glr_pkg::BOX_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [11:0] slot,
	input  logic [15:0] range_first,
	input  logic [15:0] range_length,
	input  logic [15:0] range_base,
	input  logic [31:0] entry_word,
	input  logic [15:0] char_code,
	// Result channel
	output logic        strobe,
	output logic        known,
	output logic [7:0]  glyph_width,
	output logic [31:0] glyph_address,
	output logic [7:0]  first_row,
	output logic [7:0]  row_count,
	output logic [7:0]  row_number,
	output logic [15:0] row_bits,
	output logic        last,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = (RANGES > 1) ? $clog2(RANGES) : 1;
	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(RANGES + 1);
	localparam logic [15:0] EDGE_BITS = 16'hFFFF << (16 - BOX_WIDTH);
	localparam logic [15:0] MID_BITS  = 16'h8000 | (16'h0001 << (16 - BOX_WIDTH));
	localparam logic [7:0]  BOX_W8    = 8'(BOX_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GLYPH,
		ST_BOX_INIT,
		ST_BOX_EMIT
	} state_t;

	// Configuration registers.
	logic [7:0]  font_height_q;
	logic [5:0]  range_count_q;
	logic [31:0] pixel_base_q;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_height_q <= glr_pkg::FONT_HEIGHT_RESET;
			range_count_q <= glr_pkg::RANGE_COUNT_RESET;
			pixel_base_q  <= glr_pkg::PIXEL_BASE_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				glr_pkg::REG_FONT_HEIGHT: font_height_q <= pwdata[7:0];
				glr_pkg::REG_RANGE_COUNT: range_count_q <= pwdata[5:0];
				glr_pkg::REG_PIXEL_BASE:  pixel_base_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			glr_pkg::REG_FONT_HEIGHT: prdata = {24'd0, font_height_q};
			glr_pkg::REG_RANGE_COUNT: prdata = {26'd0, range_count_q};
			glr_pkg::REG_PIXEL_BASE:  prdata = pixel_base_q;
			default:                  prdata = 32'd0;
		endcase
	end

	// Control state.
	state_t      state_q;
	logic [CW-1:0] scan_q;
	logic        rd_valid_q;
	logic [15:0] code_q;
	logic [7:0]  rows_q;
	logic [7:0]  start_row_q;
	logic [7:0]  row_q;

	// Result registers.
	logic        strobe_q;
	logic        known_q;
	logic [7:0]  width_q;
	logic [31:0] address_q;
	logic [7:0]  first_row_q;
	logic [7:0]  row_count_q;
	logic [7:0]  row_number_q;
	logic [15:0] row_bits_q;
	logic        last_q;

	logic accept;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Loads write straight into the memories at the transfer edge.
	logic range_we, glyph_we;
	assign range_we = accept && (mode == glr_pkg::MODE_LOAD_RANGE)
		&& ({20'd0, slot} < 32'(RANGES));
	assign glyph_we = accept && (mode == glr_pkg::MODE_LOAD_GLYPH)
		&& ({20'd0, slot} < 32'(ENTRIES));

	logic [47:0]   range_rdata;
	logic [31:0]   glyph_rdata;
	logic [EW-1:0] glyph_raddr;

	glr_ram #(.WIDTH(48), .DEPTH(RANGES)) u_range_ram (
		.clk   (clk),
		.we    (range_we),
		.waddr (RW'(slot)),
		.wdata ({range_first, range_length, range_base}),
		.raddr (scan_q[RW-1:0]),
		.rdata (range_rdata)
	);

	glr_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (EW'(slot)),
		.wdata (entry_word),
		.raddr (glyph_raddr),
		.rdata (glyph_rdata)
	);

	// Compare of the slot returned by the range memory.
	logic [15:0] slot_first, slot_len, slot_base, code_diff;
	logic [16:0] slot_end, index_sum;
	logic        slot_hit;
	logic [CW-1:0] scan_limit;

	assign slot_first = range_rdata[47:32];
	assign slot_len   = range_rdata[31:16];
	assign slot_base  = range_rdata[15:0];
	assign slot_end   = {1'b0, slot_first} + {1'b0, slot_len};
	assign slot_hit   = rd_valid_q && (code_q >= slot_first)
		&& ({1'b0, code_q} < slot_end);
	assign code_diff  = code_q - slot_first;
	assign index_sum  = {1'b0, slot_base} + {1'b0, code_diff};
	assign glyph_raddr = index_sum[EW-1:0];

	// Slots to scan: the smaller of range_count and RANGES.
	assign scan_limit = ({3'd0, range_count_q} < 9'(RANGES))
		? CW'(range_count_q) : CW'(RANGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			rd_valid_q   <= 1'b0;
			code_q       <= '0;
			rows_q       <= '0;
			start_row_q  <= '0;
			row_q        <= '0;
			strobe_q     <= 1'b0;
			known_q      <= 1'b0;
			width_q      <= '0;
			address_q    <= '0;
			first_row_q  <= '0;
			row_count_q  <= '0;
			row_number_q <= '0;
			row_bits_q   <= '0;
			last_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == glr_pkg::MODE_LOOKUP)) begin
						code_q     <= char_code;
						scan_q     <= '0;
						rd_valid_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// The read issued last cycle is compared while the next is issued.
					if (slot_hit) begin
						rd_valid_q <= 1'b0;
						state_q    <= ST_GLYPH;
					end else if (scan_q < scan_limit) begin
						scan_q     <= scan_q + 1'b1;
						rd_valid_q <= 1'b1;
					end else if (rd_valid_q) begin
						rd_valid_q <= 1'b0;
					end else begin
						state_q <= ST_BOX_INIT;
					end
				end
				ST_GLYPH: begin
					strobe_q     <= 1'b1;
					known_q      <= 1'b1;
					width_q      <= glyph_rdata[31:glr_pkg::WIDTH_SHIFT];
					address_q    <= pixel_base_q + (glyph_rdata & glr_pkg::OFFSET_MASK);
					first_row_q  <= '0;
					row_count_q  <= '0;
					row_number_q <= '0;
					row_bits_q   <= '0;
					last_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_BOX_INIT: begin
					if (font_height_q > BOX_W8) begin
						rows_q      <= BOX_W8;
						start_row_q <= 8'((font_height_q - BOX_W8) >> 1);
					end else begin
						rows_q      <= font_height_q;
						start_row_q <= '0;
					end
					row_q   <= '0;
					state_q <= ST_BOX_EMIT;
				end
				ST_BOX_EMIT: begin
					strobe_q     <= 1'b1;
					known_q      <= 1'b0;
					width_q      <= BOX_W8;
					address_q    <= '0;
					first_row_q  <= start_row_q;
					row_count_q  <= rows_q;
					row_number_q <= row_q;
					if (rows_q == 8'd0) begin
						row_bits_q <= '0;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						row_bits_q <= ((row_q == 8'd0) || (row_q == rows_q - 8'd1))
							? EDGE_BITS : MID_BITS;
						last_q     <= (row_q == rows_q - 8'd1);
						row_q      <= row_q + 8'd1;
						if (row_q == rows_q - 8'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe        = strobe_q;
	assign known         = known_q;
	assign glyph_width   = width_q;
	assign glyph_address = address_q;
	assign first_row     = first_row_q;
	assign row_count     = row_count_q;
	assign row_number    = row_number_q;
	assign row_bits      = row_bits_q;
	assign last          = last_q;

	// The final result of a lookup coincides with the block going idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on the final result");

	// Nothing follows the final result in the next cycle.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after the final result");

	// A hit is always a single, final result.
	a_hit_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && known |-> last && (row_count == 8'd0))
		else $error("hit result is not a lone final result");

	// Box rows carry the box width and no address.
	a_box_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !known |-> (glyph_width == BOX_W8) && (glyph_address == 32'd0))
		else $error("box row with wrong width or address");

endmodule

// ----- sim/glyph_range_locator_unit_tb.sv -----
// Self-checking testbench for the glyph range locator: random and directed items with predicted results.
`timescale 1ns / 1ps

import glr_pkg::*;

// One input item as it crosses the command channel.
typedef struct packed {
	mode_t       mode;
	logic [11:0] slot;
	logic [15:0] range_first;
	logic [15:0] range_length;
	logic [15:0] range_base;
	logic [31:0] entry_word;
	logic [15:0] char_code;
} glyph_item_t;

// One result as it appears for a single strobe cycle.
typedef struct packed {
	logic        known;
	logic [7:0]  glyph_width;
	logic [31:0] glyph_address;
	logic [7:0]  first_row;
	logic [7:0]  row_count;
	logic [7:0]  row_number;
	logic [15:0] row_bits;
	logic        last;
} glyph_result_t;

// Holds its own copy of the range tables, the glyph words and the registers, predicts the
// results of every accepted item and checks each strobed result against the oldest one owed.
class glyph_locator_scoreboard;
	logic [7:0]      font_height;
	logic [5:0]      range_count;
	logic [31:0]     pixel_base;
	logic [15:0]     slot_lo   [RANGES_DEFAULT];
	logic [15:0]     slot_len  [RANGES_DEFAULT];
	logic [15:0]     slot_base [RANGES_DEFAULT];
	logic [31:0]     glyph_words [ENTRIES_DEFAULT];
	bit              glyph_loaded [ENTRIES_DEFAULT];
	glyph_result_t   owed_results[$];
	int unsigned     mismatches;

	function new();
		font_height   = FONT_HEIGHT_RESET;
		range_count   = RANGE_COUNT_RESET;
		pixel_base    = PIXEL_BASE_RESET;
		mismatches    = 0;
	endfunction

	function void set_reg(logic [1:0] index, logic [31:0] value);
		case (index)
			REG_FONT_HEIGHT: font_height = value[7:0];
			REG_RANGE_COUNT: range_count = value[5:0];
			REG_PIXEL_BASE:  pixel_base  = value;
			default: ;
		endcase
	endfunction

	function int unsigned slots_in_use();
		return (range_count < RANGES_DEFAULT) ? range_count : RANGES_DEFAULT;
	endfunction

	// Glyph word index that a lookup of this code reads, or -1 when it misses.
	function int hit_index(logic [15:0] code);
		int unsigned lo;
		for (int k = 0; k < slots_in_use(); k++) begin
			lo = slot_lo[k];
			if (code >= lo && code < lo + slot_len[k])
				return int'((slot_base[k] + (code - lo)) % ENTRIES_DEFAULT);
		end
		return -1;
	endfunction

	// Scans the slots in order; the first one holding the code wins, else a box is drawn.
	function void locate_glyph(logic [15:0] code);
		int unsigned   lo;
		int unsigned   idx;
		int unsigned   top;
		int unsigned   rows;
		logic [31:0]   word;
		logic [15:0]   edge_bits;
		logic [15:0]   side_bits;
		glyph_result_t res;
		for (int k = 0; k < slots_in_use(); k++) begin
			lo = slot_lo[k];
			// The upper bound is taken in 32 bits, so a range never wraps past 0xFFFF.
			if (code >= lo && code < lo + slot_len[k]) begin
				idx = (slot_base[k] + (code - lo)) % ENTRIES_DEFAULT;
				word = glyph_words[idx];
				res = '0;
				res.known = 1'b1;
				res.glyph_width = 8'(word >> WIDTH_SHIFT);
				res.glyph_address = pixel_base + (word & OFFSET_MASK);
				res.last = 1'b1;
				owed_results.push_back(res);
				return;
			end
		end
		edge_bits = 16'hFFFF << (16 - BOX_WIDTH_DEFAULT);
		side_bits = 16'h8000 | (16'h0001 << (16 - BOX_WIDTH_DEFAULT));
		if (font_height > BOX_WIDTH_DEFAULT) begin
			top  = (font_height - BOX_WIDTH_DEFAULT) / 2;
			rows = BOX_WIDTH_DEFAULT;
		end else begin
			top  = 0;
			rows = font_height;
		end
		res = '0;
		res.glyph_width = 8'(BOX_WIDTH_DEFAULT);
		res.first_row = 8'(top);
		if (rows == 0) begin
			res.last = 1'b1;
			owed_results.push_back(res);
			return;
		end
		for (int r = 0; r < rows; r++) begin
			res.row_count  = 8'(rows);
			res.row_number = 8'(r);
			res.row_bits   = (r == 0 || r == rows - 1) ? edge_bits : side_bits;
			res.last       = (r == rows - 1);
			owed_results.push_back(res);
		end
	endfunction

	function void note_item(glyph_item_t it);
		case (it.mode)
			MODE_LOAD_RANGE: begin
				if (it.slot < RANGES_DEFAULT) begin
					slot_lo[it.slot]   = it.range_first;
					slot_len[it.slot]  = it.range_length;
					slot_base[it.slot] = it.range_base;
				end
			end
			MODE_LOAD_GLYPH: begin
				if (it.slot < ENTRIES_DEFAULT) begin
					glyph_words[it.slot]  = it.entry_word;
					glyph_loaded[it.slot] = 1'b1;
				end
			end
			MODE_LOOKUP: locate_glyph(it.char_code);
			default: ;
		endcase
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	task check_result(glyph_result_t got);
		glyph_result_t want;
		if (owed_results.size() == 0) begin
			report_mismatch($sformatf("result with none pending (row_number 0x%0h)",
				got.row_number));
		end else begin
			want = owed_results.pop_front();
			check_field("known", got.known, want.known);
			check_field("glyph_width", got.glyph_width, want.glyph_width);
			check_field("glyph_address", got.glyph_address, want.glyph_address);
			check_field("first_row", got.first_row, want.first_row);
			check_field("row_count", got.row_count, want.row_count);
			check_field("row_number", got.row_number, want.row_number);
			check_field("row_bits", got.row_bits, want.row_bits);
			check_field("last", got.last, want.last);
		end
	endtask
endclass

module glyph_range_locator_unit_tb;

	// Cycles without any transfer in either direction before the run is declared hung.
	// The slowest legal stretch is a long sender gap followed by a full 32-slot miss scan,
	// or a register phase with its settling pause; this is many times either.
	localparam int STALL_LIMIT = 4000;
	// Settling time after the last owed result: a full scan plus the result pipeline.
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 46;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [11:0] slot;
	logic [15:0] range_first;
	logic [15:0] range_length;
	logic [15:0] range_base;
	logic [31:0] entry_word;
	logic [15:0] char_code;
	logic        strobe;
	logic        known;
	logic [7:0]  glyph_width;
	logic [31:0] glyph_address;
	logic [7:0]  first_row;
	logic [7:0]  row_count;
	logic [7:0]  row_number;
	logic [15:0] row_bits;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	glyph_locator_scoreboard sb;
	glyph_result_t seen_result;
	int unsigned   silent_cycles;

	// Register settings per phase. The list walks the font height through the empty box,
	// the single-row box, heights on either side of the box width and the largest height,
	// and the slot count through none, one and all slots.
	logic [7:0]  phase_height [PHASES] = '{8'd16, 8'd0, 8'd1, 8'd2, 8'd255, 8'd17, 8'd15, 8'd16};
	logic [5:0]  phase_count  [PHASES] = '{6'd32, 6'd32, 6'd0, 6'd1, 6'd32, 6'd17, 6'd32, 6'd32};

	glyph_range_locator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.slot(slot),
		.range_first(range_first),
		.range_length(range_length),
		.range_base(range_base),
		.entry_word(entry_word),
		.char_code(char_code),
		.strobe(strobe),
		.known(known),
		.glyph_width(glyph_width),
		.glyph_address(glyph_address),
		.first_row(first_row),
		.row_count(row_count),
		.row_number(row_number),
		.row_bits(row_bits),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor and watchdog. Everything is sampled at the rising edge, where the values seen
	// are the ones that were stable during the cycle that the edge closes. A strobed result
	// is checked against the oldest owed result; item transfers reach the predictor from
	// the driver at the edge that takes them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silent_cycles <= 0;
		end else begin
			if (strobe) begin
				seen_result.known         = known;
				seen_result.glyph_width   = glyph_width;
				seen_result.glyph_address = glyph_address;
				seen_result.first_row     = first_row;
				seen_result.row_count     = row_count;
				seen_result.row_number    = row_number;
				seen_result.row_bits      = row_bits;
				seen_result.last          = last;
				sb.check_result(seen_result);
			end
			if ((start && !busy) || strobe) begin
				silent_cycles <= 0;
			end else if (silent_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				silent_cycles <= silent_cycles + 1;
			end
		end
	end

	// Random filler for the fields an item's mode does not use, so that every input bit
	// toggles on every kind of item.
	function automatic glyph_item_t noise_item();
		glyph_item_t it;
		it.mode         = MODE_NONE;
		it.slot         = 12'($urandom);
		it.range_first  = 16'($urandom);
		it.range_length = 16'($urandom);
		it.range_base   = 16'($urandom);
		it.entry_word   = $urandom;
		it.char_code    = 16'($urandom);
		return it;
	endfunction

	function automatic glyph_item_t make_lookup(logic [15:0] code);
		glyph_item_t it;
		it = noise_item();
		it.mode = MODE_LOOKUP;
		it.char_code = code;
		return it;
	endfunction

	function automatic glyph_item_t make_range_load(logic [11:0] where, logic [15:0] lo,
		logic [15:0] len, logic [15:0] base);
		glyph_item_t it;
		it = noise_item();
		it.mode = MODE_LOAD_RANGE;
		it.slot = where;
		it.range_first = lo;
		it.range_length = len;
		it.range_base = base;
		return it;
	endfunction

	function automatic glyph_item_t make_glyph_load(logic [11:0] where, logic [31:0] word);
		glyph_item_t it;
		it = noise_item();
		it.mode = MODE_LOAD_GLYPH;
		it.slot = where;
		it.entry_word = word;
		return it;
	endfunction

	function automatic logic [15:0] random_length();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 16'd0;
		else if (pick < 3)
			return 16'($urandom);
		else
			return 16'($urandom_range(1, 96));
	endfunction

	// Random items: half are lookups, mostly aimed at the live ranges (inside, just past the
	// end, just before the start), mixed with table loads, loads to slots past the table and
	// the unused mode code.
	function automatic glyph_item_t random_item();
		glyph_item_t it;
		int unsigned pick;
		int unsigned aim;
		int unsigned scan;
		int unsigned k;
		int unsigned code;
		it = noise_item();
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			it.mode = MODE_LOOKUP;
			scan = sb.slots_in_use();
			aim = $urandom_range(0, 99);
			if (scan != 0 && aim < 85) begin
				k = $urandom_range(0, scan - 1);
				if (aim < 65 && sb.slot_len[k] != 0)
					code = sb.slot_lo[k] + $urandom_range(0, sb.slot_len[k] - 1);
				else if (aim < 75)
					code = sb.slot_lo[k] + sb.slot_len[k];
				else
					code = sb.slot_lo[k] - 1;
				it.char_code = 16'(code);
			end
		end else if (pick < 70) begin
			it.mode = MODE_LOAD_GLYPH;
		end else if (pick < 93) begin
			it.mode = MODE_LOAD_RANGE;
			if (pick < 88) begin
				it.slot = 12'($urandom_range(0, RANGES_DEFAULT - 1));
				it.range_length = random_length();
			end
		end
		return it;
	endfunction

	// Presents one item, holds it until the block takes it and then hands it to the
	// predictor. start is left high; the caller either presents the next item at once or
	// drops start in a gap.
	task automatic send_item(input glyph_item_t it);
		start        <= 1'b1;
		mode         <= it.mode;
		slot         <= it.slot;
		range_first  <= it.range_first;
		range_length <= it.range_length;
		range_base   <= it.range_base;
		entry_word   <= it.entry_word;
		char_code    <= it.char_code;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	// A lookup whose hit would read a glyph word not yet written gets that word loaded first.
	task automatic send_lookup(input logic [15:0] code);
		int idx;
		idx = sb.hit_index(code);
		if (idx >= 0 && !sb.glyph_loaded[idx])
			send_item(make_glyph_load(12'(idx), $urandom));
		send_item(make_lookup(code));
	endtask

	// Sender idle time: mostly none or short, now and then long.
	task automatic sender_gap(input bit quiet);
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55)
			n = 0;
		else if (pick < 88)
			n = $urandom_range(1, 3);
		else if (pick < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops sending until every owed result has been seen. At least one edge always passes
	// before the check.
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.owed_results.size() != 0);
	endtask

	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup cycle, then an access cycle that completes when pready is
	// high. psel is left high so that writes run back to back; configure drops it.
	task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(index, value);
	endtask

	// Writes all three registers; only called with the block idle.
	task automatic configure(input logic [7:0] height, input logic [5:0] count,
		input logic [31:0] base);
		reg_write(REG_FONT_HEIGHT, {24'd0, height});
		reg_write(REG_RANGE_COUNT, {26'd0, count});
		reg_write(REG_PIXEL_BASE, base);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned items);
		int unsigned counted;
		bit          quiet;
		int          idx;
		glyph_item_t it;
		counted = 0;
		// About one phase in four runs with no random sender gaps, only the occasional drain.
		quiet = ($urandom_range(0, 3) == 0);
		while (counted < items) begin
			it = random_item();
			// A hit must only read a glyph word that has been written.
			if (it.mode == MODE_LOOKUP) begin
				idx = sb.hit_index(it.char_code);
				if (idx >= 0 && !sb.glyph_loaded[idx]) begin
					send_item(make_glyph_load(12'(idx), $urandom));
					counted++;
				end
			end
			send_item(it);
			counted++;
			// Now and then the sender holds off until the block has drained completely.
			if ($urandom_range(0, 39) == 0)
				wait_for_results();
			else
				sender_gap(quiet);
		end
	endtask

	initial begin
		logic [31:0] base;
		sb = new();
		arst_n       <= 1'b0;
		start        <= 1'b0;
		mode         <= MODE_NONE;
		slot         <= '0;
		range_first  <= '0;
		range_length <= '0;
		range_base   <= '0;
		entry_word   <= '0;
		char_code    <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The tables come up undefined. Every range slot is written before the first lookup,
		// and a glyph word is written just before the first lookup that would read it. Two
		// corner words go in up front: all zeros at the bottom, the widest glyph at the top.
		send_item(make_glyph_load(12'h000, 32'h0000_0000));
		send_item(make_glyph_load(12'hFFF, 32'hFF00_0000));
		for (int i = 0; i < RANGES_DEFAULT; i++) begin
			case (i)
				// Capital letters in the first slot.
				0: send_item(make_range_load(12'(i), 16'h0041, 16'd26, 16'h0000));
				// An empty range that sits on code 0 and must never match.
				1: send_item(make_range_load(12'(i), 16'h0000, 16'h0000, 16'h0123));
				// Digits whose glyph index runs past the table and wraps to its low end.
				2: send_item(make_range_load(12'(i), 16'h0030, 16'd10, 16'hFFFC));
				// Two overlapping ranges: the lower slot number wins where both hold a code.
				3: send_item(make_range_load(12'(i), 16'h4E00, 16'h0100, 16'd100));
				4: send_item(make_range_load(12'(i), 16'h4E80, 16'h0100, 16'd400));
				// A one-code range holding code 0.
				5: send_item(make_range_load(12'(i), 16'h0000, 16'h0001, 16'd7));
				// The last slot reaches past 0xFFFF, which must not wrap back to low codes.
				31: send_item(make_range_load(12'(i), 16'hFFFF, 16'hFFFF, 16'h0FFF));
				default: send_item(make_range_load(12'(i), 16'($urandom),
					16'($urandom_range(1, 64)), 16'($urandom)));
			endcase
			sender_gap(1'b1);
		end
		settle();

		// Directed lookups with a base address near the top so that addresses wrap, and a
		// 20-row line so that a miss draws a full box two rows down.
		configure(8'd20, 6'd32, 32'hFFFF_FF00);
		send_lookup(16'h0041);
		sender_gap(1'b0);
		send_lookup(16'h005A);
		sender_gap(1'b0);
		send_lookup(16'h005B);
		sender_gap(1'b0);
		send_lookup(16'h0000);
		sender_gap(1'b0);
		send_lookup(16'h0030);
		sender_gap(1'b0);
		send_lookup(16'h0039);
		sender_gap(1'b0);
		send_lookup(16'h4E90);
		sender_gap(1'b0);
		send_lookup(16'h4F10);
		sender_gap(1'b0);
		send_lookup(16'hFFFF);
		sender_gap(1'b0);
		send_lookup(16'h8000);
		sender_gap(1'b0);
		send_item(noise_item());
		sender_gap(1'b0);
		// A range load past the table must leave every slot as it was.
		send_item(make_range_load(12'hFFF, 16'h8000, 16'h0010, 16'h0000));
		sender_gap(1'b0);
		send_lookup(16'h8005);
		sender_gap(1'b0);
		// Rewrite the top glyph word with all ones: widest glyph, largest offset.
		send_item(make_glyph_load(12'hFFF, 32'hFFFF_FFFF));
		sender_gap(1'b0);
		send_lookup(16'hFFFF);
		sender_gap(1'b0);
		send_item(make_range_load(12'h000, 16'h8000, 16'h0010, 16'h0FF0));
		sender_gap(1'b0);
		send_lookup(16'h8005);
		settle();

		// Random phases, each under its own register setting. The block is drained and left
		// to settle before every register change.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1)
				base = 32'hFFFF_FFFF;
			else if (p == 2)
				base = 32'h0000_0000;
			else
				base = $urandom;
			if (p == PHASES - 1)
				configure(8'($urandom), 6'($urandom_range(0, 32)), base);
			else
				configure(phase_height[p], phase_count[p], base);
			run_phase(PHASE_ITEMS);
			settle();
		end

		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
